/* hdl/psjq_pkg.sv */
// Shared types, codes and key selection for the policy sorted job queue.
// No dependencies; used by policy_sorted_job_queue and psjq_ctrl.
package psjq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int OCC_W     = 5;

	// Request actions
	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Ordering policies; any other code orders by arrival
	localparam logic [1:0] POL_RUN     = 2'd0;
	localparam logic [1:0] POL_PRIO    = 2'd1;
	localparam logic [1:0] POL_ARRIVAL = 2'd2;

	typedef struct packed {
		logic [7:0]  tag;
		logic [15:0] run_time;
		logic [7:0]  prio;
		logic [31:0] arrival;
	} job_t;

	typedef struct packed {
		logic [1:0]       status;
		job_t             job;
		logic [OCC_W-1:0] occ;
	} res_t;

	// Select the ordering key of a job under a policy
	function automatic logic [31:0] key_of(input job_t j, input logic [1:0] pol);
		logic [31:0] k;
		unique case (pol)
			POL_RUN:  k = {16'd0, j.run_time};
			POL_PRIO: k = {24'd0, j.prio};
			default:  k = j.arrival;
		endcase
		return k;
	endfunction

endpackage

/* hdl/policy_sorted_job_queue.sv */
// Policy sorted job queue. Remove pops the head entry; full or empty status goes straight to the result.
// Add compares held entries from the head up to the insert point, then shifts the later entries up,
// one RAM read per compared or shifted entry, and writes the job into the freed slot.
// One request at a time; the next is taken once the result sits in the output register.
// Async reset empties the queue and sets policy to arrival order; RAM contents are not cleared.
// Depends on psjq_pkg, psjq_ctrl, psjq_ram.
module policy_sorted_job_queue #(
	parameter int DEPTH = psjq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  job_tag,
	input  logic [15:0] run_time,
	input  logic [7:0]  job_priority,
	input  logic [31:0] arrival,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  out_tag,
	output logic [15:0] out_run_time,
	output logic [7:0]  out_priority,
	output logic [31:0] out_arrival,
	output logic [4:0]  occupancy
);
	import psjq_pkg::*;

	logic [1:0] policy_q;
	logic       out_valid_q;
	res_t       out_q;
	logic       busy;
	logic       res_valid;
	logic       res_take;
	res_t       res;
	job_t       req_job;

	assign req_job = '{tag: job_tag, run_time: run_time, prio: job_priority, arrival: arrival};

	// Hold the policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_ARRIVAL;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	psjq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.policy    (policy_q),
		.req_valid (in_valid),
		.busy      (busy),
		.action    (action),
		.req_job   (req_job),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign in_stall = busy;
	assign res_take = !out_valid_q || !out_stall;

	// Output register: load a result when the slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign out_tag      = out_q.job.tag;
	assign out_run_time = out_q.job.run_time;
	assign out_priority = out_q.job.prio;
	assign out_arrival  = out_q.job.arrival;
	assign occupancy    = out_q.occ;

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("request not held off after accept");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DONE |-> out_tag == 8'd0 && out_arrival == 32'd0)
		else $error("failed request carries job data");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> occupancy == OCC_W'(DEPTH))
		else $error("full status with queue not full");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> occupancy == '0)
		else $error("empty status with jobs held");

endmodule

/* hdl/psjq_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module psjq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry; the read of one entry is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/psjq_ctrl.sv */
// Queue sequencer: ring of sorted jobs in RAM, scan for the insert point, shift, pop head.
// Depends on psjq_pkg and psjq_ram.
module psjq_ctrl #(
	parameter int DEPTH = psjq_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        policy,
	input  logic              req_valid,
	output logic              busy,
	input  logic              action,
	input  psjq_pkg::job_t    req_job,
	output logic              res_valid,
	input  logic              res_take,
	output psjq_pkg::res_t    res
);
	import psjq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_HEAD, S_SCAN, S_CMP, S_SHIFT, S_SHWR, S_FIN
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   pos_q;
	logic [AW-1:0]   j_q;
	job_t            job_q;
	logic [1:0]      rstat_q;
	job_t            rjob_q;

	logic            we;
	logic [AW-1:0]   waddr;
	job_t            wdata;
	logic [AW-1:0]   raddr;
	job_t            rdata;

	// Map a position from the head to a RAM address
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] l);
		logic [AW:0] s;
		s = {1'b0, h} + {1'b0, l};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	psjq_ram #(.WIDTH($bits(job_t)), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Drive RAM accesses for the current step
	always_comb begin
		raddr = head_q;
		we    = 1'b0;
		waddr = head_q;
		wdata = job_q;
		unique case (state_q)
			S_SCAN: raddr = phys(head_q, pos_q);
			S_SHIFT: begin
				if (j_q == pos_q) begin
					we    = 1'b1;
					waddr = phys(head_q, pos_q);
				end else begin
					raddr = phys(head_q, j_q - AW'(1));
				end
			end
			S_SHWR: begin
				we    = 1'b1;
				waddr = phys(head_q, j_q);
				wdata = rdata;
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res.status = rstat_q;
	assign res.job    = rjob_q;
	assign res.occ    = OCC_W'(count_q);

	// Sequence one request at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			pos_q   <= '0;
			j_q     <= '0;
			job_q   <= '0;
			rstat_q <= ST_DONE;
			rjob_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						rjob_q  <= '0;
						rstat_q <= ST_DONE;
						job_q   <= req_job;
						pos_q   <= '0;
						if (action == ACT_REMOVE) begin
							if (count_q == '0) begin
								rstat_q <= ST_EMPTY;
								state_q <= S_FIN;
							end else begin
								state_q <= S_HEAD;
							end
						end else if (count_q == CW'(DEPTH)) begin
							rstat_q <= ST_FULL;
							state_q <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_HEAD: begin
					rjob_q  <= rdata;
					head_q  <= phys(head_q, AW'(1));
					count_q <= count_q - CW'(1);
					state_q <= S_FIN;
				end
				S_SCAN: begin
					if (CW'(pos_q) == count_q) begin
						j_q     <= count_q[AW-1:0];
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (key_of(rdata, policy) <= key_of(job_q, policy)) begin
						pos_q   <= pos_q + AW'(1);
						state_q <= S_SCAN;
					end else begin
						j_q     <= count_q[AW-1:0];
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (j_q == pos_q) begin
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					j_q     <= j_q - AW'(1);
					state_q <= S_SHIFT;
				end
				S_FIN: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
